// File: hdl/sorted_name_table_lookup_macros.svh
// assertion macros for the name table
`ifndef SORTED_NAME_TABLE_LOOKUP_MACROS_SVH
`define SORTED_NAME_TABLE_LOOKUP_MACROS_SVH

// property must hold at every clock edge outside reset
`define SNTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SNTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sntl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sntl_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int NAME_CHARS  = 12;
  localparam int NAME_BITS   = 96;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_SORT   = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  localparam logic [7:0] DEFAULT_TYPE_RESET = 8'd67;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] name_head;
    logic [31:0] name_tail;
    logic [7:0]  entry_type;
  } in_req_t;

  typedef struct packed {
    logic       accepted;
    logic       found;
    logic [7:0] result_type;
  } out_req_t;

  // zero after the first zero byte, drop past NAME_CHARS, fold upper case
  function automatic logic [NAME_BITS-1:0] make_key(input logic [63:0] head,
                                                    input logic [31:0] tail);
    logic [NAME_BITS-1:0] raw;
    logic [NAME_BITS-1:0] key;
    logic                 ended;
    logic [7:0]           c;
    raw   = {head, tail};
    key   = '0;
    ended = 1'b0;
    for (int k = 0; k < 12; k++) begin
      c = raw[NAME_BITS-1-8*k -: 8];
      if (k >= NAME_CHARS || c == 8'd0) begin
        ended = 1'b1;
      end
      if (ended) begin
        c = 8'd0;
      end
      if (c >= 8'h41 && c <= 8'h5a) begin
        c = c + 8'h20;
      end
      key[NAME_BITS-1-8*k -: 8] = c;
    end
    return key;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sorted_name_table_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// sorted name table: holds up to 512 entries of a 12-character name key and
// a type byte in one dual-port memory (one read, one write port, registered
// read). each request takes a mode. clear and append: the request is taken,
// then the result moves to the output register. a lookup is a binary search
// of at most 10 probes, and the next read address is issued in the same
// cycle that compares the current entry. sort is an exchange sort: each row
// reads entry i, then entry j, then compares one pair per step, and a swap
// writes entry j and then entry i. one request is in work at a time; the
// result sits in an output register so the next request is taken while a
// result waits. default_type is written only while idle with no request
// offered and no result held.
`include "sorted_name_table_lookup_macros.svh"
module sorted_name_table_lookup (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sntl_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sntl_pkg::out_req_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  localparam int AW = sntl_pkg::ADDR_W;
  localparam int CW = sntl_pkg::CNT_W;
  localparam int NB = sntl_pkg::NAME_BITS;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RD_I   = 7'b0000010,  // read entry i
    ST_RD_J   = 7'b0000100,  // read entry j, latch i
    ST_CMP    = 7'b0001000,  // compare i/j, write j on swap
    ST_WR_I   = 7'b0010000,  // write second half of swap
    ST_PROBE  = 7'b0100000,  // lookup read issued
    ST_DONE   = 7'b1000000
  } state_t;

  // table memory, name and type side by side
  logic [NB+7:0] mem [sntl_pkg::TABLE_DEPTH];
  logic [NB+7:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [NB+7:0] wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [7:0]         dflt_r;
  logic [NB-1:0]      key_r, key_nxt;
  logic [NB+7:0]      ent_i_r, ent_i_nxt;   // held entry i during sort
  logic [AW-1:0]      i_r, i_nxt, j_r, j_nxt;
  logic signed [CW:0] left_r, left_nxt, right_r, right_nxt;
  logic [AW-1:0]      pivot_r, pivot_nxt;
  logic               out_valid_r, out_valid_nxt;
  sntl_pkg::out_req_t out_r, out_nxt;
  sntl_pkg::out_req_t res_r, res_nxt;       // result waiting for output reg

  logic take;
  logic signed [CW:0] mid;
  logic [NB-1:0] rd_name;

  assign in_stall  = (state_r != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE) && !out_valid_r && !in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rd_name   = rd_data[NB+7:8];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    ent_i_nxt     = ent_i_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    pivot_nxt     = pivot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mid           = '0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          res_nxt = '{accepted: 1'b1, found: 1'b0, result_type: 8'd0};
          key_nxt = sntl_pkg::make_key(in_data.name_head, in_data.name_tail);
          case (in_data.mode)
            sntl_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            sntl_pkg::MODE_APPEND: begin
              if (count_r == CW'(sntl_pkg::TABLE_DEPTH)) begin
                res_nxt.accepted = 1'b0;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = {key_nxt, in_data.entry_type};
                count_nxt = count_r + 1'b1;
              end
              state_nxt = ST_DONE;
            end
            sntl_pkg::MODE_SORT: begin
              i_nxt = '0;
              j_nxt = AW'(1);
              state_nxt = (count_r > CW'(1)) ? ST_RD_I : ST_DONE;
            end
            default: begin
              res_nxt.result_type = dflt_r;
              left_nxt  = '0;
              right_nxt = $signed({1'b0, count_r} - 1'b1);
              mid       = (left_nxt + right_nxt) >>> 1;
              if (count_r == '0) begin
                state_nxt = ST_DONE;
              end else begin
                pivot_nxt = mid[AW-1:0];
                rd_addr   = mid[AW-1:0];
                state_nxt = ST_PROBE;
              end
            end
          endcase
        end
      end
      ST_RD_I: begin
        rd_addr   = i_r;
        state_nxt = ST_RD_J;
      end
      ST_RD_J: begin
        ent_i_nxt = rd_data;
        rd_addr   = j_r;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // rd_data holds entry j here
        if (ent_i_r[NB+7:8] > rd_name) begin
          wr_en     = 1'b1;
          wr_addr   = j_r;
          wr_data   = ent_i_r;
          ent_i_nxt = rd_data;
          state_nxt = ST_WR_I;
        end else if ({1'b0, j_r} + 1'b1 < count_r) begin
          j_nxt     = j_r + 1'b1;
          rd_addr   = j_r + 1'b1;
          state_nxt = ST_CMP;
        end else if ({1'b0, i_r} + 2'd2 < count_r) begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = i_r + 2'd2;
          state_nxt = ST_RD_I;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WR_I: begin
        // entry i now holds the smaller name, kept in ent_i_r
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = ent_i_r;
        if ({1'b0, j_r} + 1'b1 < count_r) begin
          j_nxt     = j_r + 1'b1;
          rd_addr   = j_r + 1'b1;
          state_nxt = ST_CMP;
        end else if ({1'b0, i_r} + 2'd2 < count_r) begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = i_r + 2'd2;
          state_nxt = ST_RD_I;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PROBE: begin
        if (key_r == rd_name) begin
          res_nxt.found       = 1'b1;
          res_nxt.result_type = rd_data[7:0];
          state_nxt           = ST_DONE;
        end else begin
          if (key_r > rd_name) begin
            left_nxt = $signed({2'b0, pivot_r} + 1'b1);
          end else begin
            right_nxt = $signed({2'b0, pivot_r} - 1'b1);
          end
          mid = (left_nxt + right_nxt) >>> 1;
          if (left_nxt <= right_nxt) begin
            pivot_nxt = mid[AW-1:0];
            rd_addr   = mid[AW-1:0];
            state_nxt = ST_PROBE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dflt_r      <= sntl_pkg::DEFAULT_TYPE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        dflt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    ent_i_r <= ent_i_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    pivot_r <= pivot_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // checks
  `SNTL_ASSERT(a_count_range, count_r <= CW'(sntl_pkg::TABLE_DEPTH), "entry count overflow")
  `SNTL_ASSERT_NEXT(a_hold_out, out_valid_r && out_stall, out_valid_r && $stable(out_r),
                    "result lost under stall")
  `SNTL_ASSERT_NEXT(a_take_leaves_idle, take, state_r != ST_IDLE, "request taken but idle")

endmodule
`default_nettype wire

// File: test/tb_sorted_name_table_lookup.sv
`timescale 1ns / 1ps
module tb_sorted_name_table_lookup;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sntl_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sntl_pkg::out_req_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;

  always #4 clk = ~clk;

  sorted_name_table_lookup dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow copy of the table, kept in step with accepted requests
  logic [sntl_pkg::NAME_BITS-1:0] shadow_names [sntl_pkg::TABLE_DEPTH];
  logic [7:0]                     shadow_types [sntl_pkg::TABLE_DEPTH];
  int                             shadow_count = 0;
  logic [7:0]                     miss_type = sntl_pkg::DEFAULT_TYPE_RESET;

  sntl_pkg::in_req_t  pending_reqs [$];
  sntl_pkg::out_req_t expected_results [$];
  int       errors = 0;
  bit       activity;

  // fold a raw name into its table key
  function automatic logic [sntl_pkg::NAME_BITS-1:0] fold_name(logic [63:0] head,
                                                               logic [31:0] tail);
    logic [sntl_pkg::NAME_BITS-1:0] raw;
    logic [sntl_pkg::NAME_BITS-1:0] key;
    logic [7:0] ch;
    bit done;
    raw = {head, tail};
    key = '0;
    done = 0;
    for (int k = 0; k < 12; k++) begin
      ch = raw[sntl_pkg::NAME_BITS-1-8*k -: 8];
      if (k >= sntl_pkg::NAME_CHARS || ch == 8'd0) done = 1;
      if (done) ch = 8'd0;
      if (ch >= "A" && ch <= "Z") ch = ch + 8'h20;
      key[sntl_pkg::NAME_BITS-1-8*k -: 8] = ch;
    end
    return key;
  endfunction

  // apply one request to the shadow table and return the answer it should give
  function automatic sntl_pkg::out_req_t table_answer(sntl_pkg::in_req_t r);
    sntl_pkg::out_req_t res;
    logic [sntl_pkg::NAME_BITS-1:0] key;
    logic [sntl_pkg::NAME_BITS-1:0] tn;
    logic [7:0] tt;
    int lo, hi, mid;
    res = '{accepted: 1'b1, found: 1'b0, result_type: 8'd0};
    case (r.mode)
      sntl_pkg::MODE_CLEAR: begin
        shadow_count = 0;
      end
      sntl_pkg::MODE_APPEND: begin
        if (shadow_count >= sntl_pkg::TABLE_DEPTH) begin
          res.accepted = 1'b0;
        end else begin
          shadow_names[shadow_count] = fold_name(r.name_head, r.name_tail);
          shadow_types[shadow_count] = r.entry_type;
          shadow_count++;
        end
      end
      sntl_pkg::MODE_SORT: begin
        for (int i = 0; i < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if (shadow_names[i] > shadow_names[j]) begin
              tn = shadow_names[i]; shadow_names[i] = shadow_names[j]; shadow_names[j] = tn;
              tt = shadow_types[i]; shadow_types[i] = shadow_types[j]; shadow_types[j] = tt;
            end
      end
      default: begin
        key = fold_name(r.name_head, r.name_tail);
        res.result_type = miss_type;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (key == shadow_names[mid]) begin
            res.found = 1'b1;
            res.result_type = shadow_types[mid];
            break;
          end else if (key > shadow_names[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: random gaps between requests, some stretches with none
  // ---------------------------------------------------------------------------
  bit in_took = 0;
  int in_gap = 0;
  bit in_burst = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(table_answer(in_data));
      in_took = 1;
    end
  end

  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (in_took) begin
      in_took = 0;
      next_valid = 1'b0;
      if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
      in_gap = in_burst ? 0 : $urandom_range(0, 16);
    end
    if (rst_n && !next_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stalls, with one long hold-off on request
  // ---------------------------------------------------------------------------
  int  out_wait = 0;
  bit  out_burst = 0;
  bit  hold_request = 0;
  int  hold_left = 0;

  always @(posedge clk) begin
    sntl_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(out_data), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.accepted !== want.accepted)
          report_mismatch("accepted", out_data.accepted, want.accepted);
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.result_type !== want.result_type)
          report_mismatch("result_type", out_data.result_type, want.result_type);
      end
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      out_wait = out_burst ? 0 : $urandom_range(0, 16);
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    activity = (in_valid && !in_stall) || (out_valid && !out_stall) ||
               (cfg_valid && cfg_ready);
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    #1;
    if (activity || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("sorted_name_table_lookup test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sntl_pkg::in_req_t make_req(logic [1:0] m,
                                                 logic [sntl_pkg::NAME_BITS-1:0] nm,
                                                 logic [7:0] t);
    sntl_pkg::in_req_t r;
    r.mode = m;
    r.name_head = nm[95:32];
    r.name_tail = nm[31:0];
    r.entry_type = t;
    return r;
  endfunction

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "_"));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // random name, sometimes with junk after the terminating zero
  function automatic logic [sntl_pkg::NAME_BITS-1:0] random_name();
    logic [sntl_pkg::NAME_BITS-1:0] nm;
    int len;
    bit junk;
    len = $urandom_range(0, 12);
    junk = ($urandom_range(0, 3) == 0);
    nm = '0;
    for (int k = 0; k < 12; k++) begin
      if (k < len) nm[95-8*k -: 8] = random_char();
      else if (k > len && junk) nm[95-8*k -: 8] = 8'($urandom);
    end
    return nm;
  endfunction

  // same key, letters flipped between cases at random
  function automatic logic [sntl_pkg::NAME_BITS-1:0] case_variant(
      logic [sntl_pkg::NAME_BITS-1:0] nm);
    logic [7:0] ch;
    for (int k = 0; k < 12; k++) begin
      ch = nm[95-8*k -: 8];
      if (((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) && $urandom_range(0, 1))
        nm[95-8*k -: 8] = ch ^ 8'h20;
    end
    return nm;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_miss_type(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    miss_type = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one sequence: usually a clear, a fill, usually a sort, then lookups mixed with random requests
  task automatic table_session();
    logic [sntl_pkg::NAME_BITS-1:0] names [16];
    int fill;
    for (int k = 0; k < 16; k++) names[k] = random_name();
    if ($urandom_range(0, 9) != 0 || shadow_count > 30)
      pending_reqs.push_back(make_req(sntl_pkg::MODE_CLEAR, '0, '0));
    fill = $urandom_range(1, 14);
    for (int k = 0; k < fill; k++)
      pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, names[$urandom_range(0, 15)],
                                      8'($urandom)));
    if ($urandom_range(0, 7) != 0)
      pending_reqs.push_back(make_req(sntl_pkg::MODE_SORT, names[0], 8'($urandom)));
    for (int k = $urandom_range(2, 8); k > 0; k--) begin
      case ($urandom_range(0, 5))
        0: pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, random_name(),
                                           8'($urandom)));
        1: pending_reqs.push_back(make_req(2'($urandom),
                                  {$urandom, $urandom, $urandom}, 8'($urandom)));
        default: pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP,
                                  case_variant(names[$urandom_range(0, 15)]), 8'($urandom)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [sntl_pkg::NAME_BITS-1:0] full_name;
    int rounds;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: miss with the reset default, sort does nothing
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"wall", 64'h0}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_SORT, '0, 8'd0));
    // extremes of every field, case folding and junk after the terminator
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, {96{1'b1}}, 8'hff));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, '0, 8'h00));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, {"ZZTOP", 56'h0}, 8'h11));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, {"ab", 8'h00, "junkjunk!"},
                                    8'h22));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, "Metal_Floor1", 8'h33));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, {"grass", 56'h0}, 8'h44));
    // unsorted table is still searched
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"GRASS", 56'h0}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_SORT, '0, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"zztop", 56'h0}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"AB", 8'h00, "other-jun"},
                                    8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, "metal_floor1", 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {96{1'b1}}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, '0, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"missing", 40'h0}, 8'd0));
    wait_idle();
    set_miss_type(8'd0);
    // clear keeps old entries in memory but they must not be found
    pending_reqs.push_back(make_req(sntl_pkg::MODE_CLEAR, '0, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"grass", 56'h0}, 8'd0));
    wait_idle();
    set_miss_type(8'd255);

    // fill to the top, then one append too many
    for (int k = 0; k < sntl_pkg::TABLE_DEPTH; k++) begin
      full_name = {"e", 8'(k >> 8), 8'(k), {9{8'h00}}};
      if (k[8]) full_name[87:80] = 8'(k >> 8) | 8'h80;
      pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, full_name, 8'(k)));
    end
    pending_reqs.push_back(make_req(sntl_pkg::MODE_APPEND, {"overflow", 32'h0}, 8'h5a));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP,
                                    {"e", 8'h81, 8'h07, {9{8'h00}}}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP,
                                    {"e", 8'h00, {10{8'h00}}}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, {"overflow", 32'h0}, 8'd0));
    pending_reqs.push_back(make_req(sntl_pkg::MODE_CLEAR, '0, 8'd0));
    wait_idle();

    // random sessions, with a fresh miss type every so often
    rounds = 0;
    while (rounds < 4) begin
      if (rounds == 2) begin
        // long receiver hold-off while requests keep coming
        for (int k = 0; k < 20; k++)
          pending_reqs.push_back(make_req(sntl_pkg::MODE_LOOKUP, random_name(),
                                          8'($urandom)));
        hold_request = 1;
      end
      table_session();
      rounds++;
      if (rounds % 2 == 0) begin
        wait_idle();
        set_miss_type(8'($urandom));
      end
    end
    wait_idle();
    set_miss_type(sntl_pkg::DEFAULT_TYPE_RESET);
    table_session();
    wait_idle();
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("sorted_name_table_lookup test passed");
    end else begin
      $display("sorted_name_table_lookup test failed");
    end
    $finish;
  end

endmodule
